// ===== rtl/bar_flt_pkg.sv =====
// ----------------------------------------------------------------------------
// bar_flt_pkg
// Shared constants, codes and controller/datapath signal groups for the
// beacon advertisement relay filter.
// ----------------------------------------------------------------------------
package bar_flt_pkg;

    localparam int TABLE_ENTRIES_DEF = 512;
    localparam int PACKET_BYTES_DEF  = 31;

    localparam int CFG_W   = 16;
    localparam int CFG_IDX = 2;
    localparam int ADDR_W  = 48;

    localparam logic [CFG_IDX-1:0] REG_COMPANY = 2'd0;
    localparam logic [CFG_IDX-1:0] REG_MSGTYPE = 2'd1;
    localparam logic [CFG_IDX-1:0] REG_PAYLEN  = 2'd2;
    localparam logic [CFG_IDX-1:0] REG_MARKER  = 2'd3;

    localparam logic [15:0] COMPANY_RST = 16'h004C;
    localparam logic [7:0]  MSGTYPE_RST = 8'h12;
    localparam logic [7:0]  PAYLEN_RST  = 8'h19;
    localparam logic [7:0]  MARKER_RST  = 8'hFF;

    localparam logic [7:0] AD_TYPE_VENDOR = 8'hFF;
    localparam int         HOP_POS        = 6;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    localparam logic [2:0] V_NONE      = 3'd0;
    localparam logic [2:0] V_MISMATCH  = 3'd1;
    localparam logic [2:0] V_STORED    = 3'd2;
    localparam logic [2:0] V_EXPIRED   = 3'd3;
    localparam logic [2:0] V_NOT_OURS  = 3'd4;
    localparam logic [2:0] V_DUPLICATE = 3'd5;
    localparam logic [2:0] V_FULL      = 3'd6;
    localparam logic [2:0] V_READ      = 3'd7;

    typedef struct packed {
        logic       sweep_en;
        logic       byte_we;
        logic       clear_tab;
        logic       rd_issue;
        logic       cnt_vendor;
        logic       k_clr;
        logic       k_inc;
        logic       tab_rd;
        logic       tab_wr;
        logic       c_inc;
        logic       line_rd;
        logic       pay_wr;
        logic       count_inc;
        logic       out_load;
        logic       pkt_done;
        logic [2:0] verdict;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic vendor;
        logic match;
        logic expired;
        logic not_ours;
        logic count_zero;
        logic full;
        logic addr_eq;
        logic k_last;
        logic c_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/bar_flt_in_if.sv =====
// ----------------------------------------------------------------------------
// bar_flt_in_if
// Input channel: one advertisement byte, clear or read request per transaction.
// ----------------------------------------------------------------------------
interface bar_flt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [47:0] sender_address;
    logic [8:0]  read_slot;
    logic [4:0]  read_index;

    modport source (
        output valid, opcode, data_byte, first_byte, last_byte,
               sender_address, read_slot, read_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, data_byte, first_byte, last_byte,
               sender_address, read_slot, read_index,
        output ready
    );
endinterface

// ===== rtl/bar_flt_out_if.sv =====
// ----------------------------------------------------------------------------
// bar_flt_out_if
// Result channel: one verdict or read reply per transaction.
// ----------------------------------------------------------------------------
interface bar_flt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [8:0]  stored_slot;
    logic [9:0]  entry_total;
    logic [31:0] vendor_packets;
    logic [7:0]  read_data;

    modport source (
        output valid, verdict, stored_slot, entry_total, vendor_packets, read_data,
        input  ready
    );
    modport sink (
        input  valid, verdict, stored_slot, entry_total, vendor_packets, read_data,
        output ready
    );
endinterface

// ===== rtl/bar_flt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bar_flt_ctrl
// Sequencer: clearing pass, packet finish, table search, row copy and
// result hand-off.
// ----------------------------------------------------------------------------
module bar_flt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_opcode,
    input  logic                 i_last,
    output logic                 o_in_ready,
    input  bar_flt_pkg::t_status i_st,
    output bar_flt_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FIN   = 3'd2;
    localparam logic [2:0] S_SRD   = 3'd3;
    localparam logic [2:0] S_SCMP  = 3'd4;
    localparam logic [2:0] S_CRD   = 3'd5;
    localparam logic [2:0] S_CWR   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_verdict, n_verdict;
    logic       acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_verdict = r_verdict;
        o_cmd     = '0;
        o_cmd.verdict = r_verdict;
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_en = 1'b1;
                if (i_st.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    case (i_opcode)
                        bar_flt_pkg::OP_BYTE: begin
                            o_cmd.byte_we = 1'b1;
                            if (i_last) begin
                                n_state = S_FIN;
                            end
                        end
                        bar_flt_pkg::OP_CLEAR: o_cmd.clear_tab = 1'b1;
                        bar_flt_pkg::OP_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_verdict = bar_flt_pkg::V_READ;
                            n_state   = S_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_FIN: begin
                o_cmd.cnt_vendor = i_st.vendor;
                o_cmd.k_clr      = 1'b1;
                n_state          = S_EMIT;
                if (!i_st.vendor) begin
                    n_verdict = bar_flt_pkg::V_NONE;
                end else if (!i_st.match) begin
                    n_verdict = bar_flt_pkg::V_MISMATCH;
                end else if (i_st.expired) begin
                    n_verdict = bar_flt_pkg::V_EXPIRED;
                end else if (i_st.not_ours) begin
                    n_verdict = bar_flt_pkg::V_NOT_OURS;
                end else if (i_st.count_zero) begin
                    o_cmd.tab_wr = 1'b1;
                    n_state      = S_CRD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.tab_rd = 1'b1;
                n_state      = S_SCMP;
            end
            S_SCMP: begin
                o_cmd.k_inc = 1'b1;
                if (i_st.addr_eq) begin
                    n_verdict = bar_flt_pkg::V_DUPLICATE;
                    n_state   = S_EMIT;
                end else if (i_st.k_last) begin
                    if (i_st.full) begin
                        n_verdict = bar_flt_pkg::V_FULL;
                        n_state   = S_EMIT;
                    end else begin
                        o_cmd.tab_wr = 1'b1;
                        n_state      = S_CRD;
                    end
                end else begin
                    n_state = S_SRD;
                end
            end
            S_CRD: begin
                o_cmd.line_rd = 1'b1;
                n_state       = S_CWR;
            end
            S_CWR: begin
                o_cmd.pay_wr = 1'b1;
                if (i_st.c_last) begin
                    o_cmd.count_inc = 1'b1;
                    n_verdict       = bar_flt_pkg::V_STORED;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.c_inc = 1'b1;
                    n_state     = S_CRD;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.pkt_done = (r_verdict != bar_flt_pkg::V_READ);
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_verdict <= bar_flt_pkg::V_NONE;
        end else begin
            r_state   <= n_state;
            r_verdict <= n_verdict;
        end
    end

endmodule

// ===== rtl/bar_flt_dp.sv =====
// ----------------------------------------------------------------------------
// bar_flt_dp
// Datapath: configuration, packet line and structure walk, address table,
// payload store, counters and result register.
// ----------------------------------------------------------------------------
module bar_flt_dp #(
    parameter int TABLE_ENTRIES = bar_flt_pkg::TABLE_ENTRIES_DEF,
    parameter int PACKET_BYTES  = bar_flt_pkg::PACKET_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bar_flt_pkg::t_cmd                i_cmd,
    output bar_flt_pkg::t_status             o_st,
    input  logic                             i_cfg_we,
    input  logic [bar_flt_pkg::CFG_IDX-1:0]  i_cfg_index,
    input  logic [bar_flt_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_first,
    input  logic                             i_last,
    input  logic [bar_flt_pkg::ADDR_W-1:0]   i_addr,
    input  logic [8:0]                       i_rd_slot,
    input  logic [4:0]                       i_rd_index,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_verdict,
    output logic [8:0]                       o_stored_slot,
    output logic [9:0]                       o_entry_total,
    output logic [31:0]                      o_vendor_packets,
    output logic [7:0]                       o_read_data
);

    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int POS_W  = $clog2(PACKET_BYTES + 1);
    localparam int IDX_W  = $clog2(PACKET_BYTES);
    localparam int DEPTH  = TABLE_ENTRIES * PACKET_BYTES;
    localparam int MADR_W = $clog2(DEPTH);

    logic [15:0] r_company;
    logic [7:0]  r_msgtype, r_paylen, r_marker;

    logic [7:0] line_mem [PACKET_BYTES];
    logic [bar_flt_pkg::ADDR_W-1:0] tab_mem [TABLE_ENTRIES];
    logic [7:0] pay_mem [DEPTH];

    logic [POS_W-1:0] r_pos, n_pos, pos_eff, r_c;
    logic [8:0]  r_next, n_next;
    logic [7:0]  r_cur, n_cur, r_len, n_len, r_type, n_type, r_clo, n_clo, r_hop, n_hop;
    logic [7:0]  off;
    logic        r_vendor, n_vendor, r_match, n_match, r_curv, n_curv, r_mtok, n_mtok;
    logic [bar_flt_pkg::ADDR_W-1:0] r_addr, r_tab_q;
    logic [7:0]  r_line_q, r_mem_q, pay_wdata;
    logic        r_rd_ok;
    logic [CNT_W-1:0]  r_count, r_k;
    logic [SLOT_W-1:0] r_slot;
    logic [MADR_W-1:0] r_sweep, pay_waddr, rd_addr;
    logic [31:0] r_vcount;
    logic        r_out_valid;
    logic        in_rng, walk_reset;

    assign pos_eff    = i_first ? '0 : r_pos;
    assign walk_reset = (pos_eff == '0);

    // byte position and on-the-fly structure walk
    always_comb begin
        n_pos    = pos_eff;
        n_next   = walk_reset ? 9'd0 : r_next;
        n_cur    = r_cur;
        n_len    = r_len;
        n_type   = r_type;
        n_clo    = r_clo;
        n_hop    = r_hop;
        n_vendor = walk_reset ? 1'b0 : r_vendor;
        n_match  = walk_reset ? 1'b0 : r_match;
        n_curv   = r_curv;
        n_mtok   = r_mtok;
        off      = 8'(pos_eff) - r_cur;
        if (32'(pos_eff) < PACKET_BYTES) begin
            n_pos = pos_eff + POS_W'(1);
            if (32'(pos_eff) == bar_flt_pkg::HOP_POS) begin
                n_hop = i_data_byte;
            end
            if (9'(pos_eff) == n_next) begin
                n_len  = i_data_byte;
                n_cur  = 8'(pos_eff);
                n_next = 9'(pos_eff) + 9'(i_data_byte) + 9'd1;
                n_curv = 1'b0;
            end else begin
                case (off)
                    8'd1: n_type = i_data_byte;
                    8'd2: n_clo  = i_data_byte;
                    8'd3: begin
                        if (r_len >= 8'd3 && r_type == bar_flt_pkg::AD_TYPE_VENDOR &&
                            {i_data_byte, r_clo} == r_company) begin
                            n_vendor = 1'b1;
                            n_match  = 1'b0;
                            n_curv   = 1'b1;
                        end else begin
                            n_curv = 1'b0;
                        end
                    end
                    8'd4: n_mtok = (i_data_byte == r_msgtype);
                    8'd5: begin
                        if (r_curv && r_len >= 8'd5 && r_mtok && i_data_byte == r_paylen) begin
                            n_match = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign in_rng    = (32'(i_rd_slot) < TABLE_ENTRIES) && (32'(i_rd_index) < PACKET_BYTES);
    assign rd_addr   = MADR_W'(i_rd_slot) * MADR_W'(PACKET_BYTES) + MADR_W'(i_rd_index);
    assign pay_waddr = i_cmd.sweep_en ? r_sweep :
                       MADR_W'(r_slot) * MADR_W'(PACKET_BYTES) + MADR_W'(r_c);
    assign pay_wdata = i_cmd.sweep_en ? 8'd0 :
                       (32'(r_c) == bar_flt_pkg::HOP_POS) ? r_hop - 8'd1 : r_line_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_we && 32'(pos_eff) < PACKET_BYTES) begin
            line_mem[pos_eff[IDX_W-1:0]] <= i_data_byte;
        end
        if (i_cmd.line_rd) begin
            r_line_q <= line_mem[r_c[IDX_W-1:0]];
        end
        if (i_cmd.tab_wr) begin
            tab_mem[r_count[SLOT_W-1:0]] <= r_addr;
        end
        if (i_cmd.tab_rd) begin
            r_tab_q <= tab_mem[r_k[SLOT_W-1:0]];
        end
        if (i_cmd.sweep_en || i_cmd.pay_wr) begin
            pay_mem[pay_waddr] <= pay_wdata;
        end
        if (i_cmd.rd_issue) begin
            r_mem_q <= pay_mem[rd_addr];
            r_rd_ok <= in_rng;
        end
        if (i_cmd.byte_we) begin
            r_next <= n_next;
            r_cur  <= n_cur;
            r_len  <= n_len;
            r_type <= n_type;
            r_clo  <= n_clo;
            r_hop  <= n_hop;
            r_curv <= n_curv;
            r_mtok <= n_mtok;
            if (i_last) begin
                r_addr <= i_addr;
            end
        end
        if (i_cmd.tab_wr) begin
            r_slot <= r_count[SLOT_W-1:0];
        end
        if (i_cmd.out_load) begin
            o_verdict        <= i_cmd.verdict;
            o_stored_slot    <= (i_cmd.verdict == bar_flt_pkg::V_STORED) ? 9'(r_slot) : 9'd0;
            o_entry_total    <= 10'(r_count);
            o_vendor_packets <= r_vcount;
            o_read_data      <= (i_cmd.verdict == bar_flt_pkg::V_READ && r_rd_ok) ?
                                r_mem_q : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_company   <= bar_flt_pkg::COMPANY_RST;
            r_msgtype   <= bar_flt_pkg::MSGTYPE_RST;
            r_paylen    <= bar_flt_pkg::PAYLEN_RST;
            r_marker    <= bar_flt_pkg::MARKER_RST;
            r_pos       <= '0;
            r_vendor    <= 1'b0;
            r_match     <= 1'b0;
            r_count     <= '0;
            r_k         <= '0;
            r_c         <= '0;
            r_sweep     <= '0;
            r_vcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bar_flt_pkg::REG_COMPANY: r_company <= i_cfg_data;
                    bar_flt_pkg::REG_MSGTYPE: r_msgtype <= i_cfg_data[7:0];
                    bar_flt_pkg::REG_PAYLEN:  r_paylen  <= i_cfg_data[7:0];
                    bar_flt_pkg::REG_MARKER:  r_marker  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.byte_we) begin
                r_pos    <= n_pos;
                r_vendor <= n_vendor;
                r_match  <= n_match;
            end else if (i_cmd.pkt_done) begin
                r_pos <= '0;
            end
            if (i_cmd.sweep_en) begin
                r_sweep <= r_sweep + MADR_W'(1);
            end
            if (i_cmd.clear_tab) begin
                r_count <= '0;
            end else if (i_cmd.count_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + CNT_W'(1);
            end
            if (i_cmd.tab_wr) begin
                r_c <= '0;
            end else if (i_cmd.c_inc) begin
                r_c <= r_c + POS_W'(1);
            end
            if (i_cmd.cnt_vendor) begin
                r_vcount <= r_vcount + 32'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_st.sweep_last = (r_sweep == MADR_W'(DEPTH - 1));
    assign o_st.vendor     = r_vendor;
    assign o_st.match      = r_match;
    assign o_st.expired    = (32'(r_pos) <= bar_flt_pkg::HOP_POS) || (r_hop == 8'd0);
    assign o_st.not_ours   = (r_addr[15:8] != r_marker);
    assign o_st.count_zero = (r_count == '0);
    assign o_st.full       = (r_count == CNT_W'(TABLE_ENTRIES));
    assign o_st.addr_eq    = (r_tab_q == r_addr);
    assign o_st.k_last     = ((r_k + CNT_W'(1)) == r_count);
    assign o_st.c_last     = ((r_c + POS_W'(1)) == r_pos);
    assign o_st.out_free   = !r_out_valid || i_ready;

endmodule

// ===== rtl/beacon_advert_relay_filter_unit.sv =====
// ----------------------------------------------------------------------------
// beacon_advert_relay_filter_unit
// Relay filter for beacon advertisements: vendor structure check, hop count,
// address table with duplicate search and packet store.
//
// i_in_ch carries one transaction per advertisement byte, clear or read.
// o_out_ch returns one verdict per packet end and one reply per read.
// Bytes without the last mark are taken back to back. At a packet end the
// packet is checked, the stored addresses are searched one by one for a
// duplicate over the single-port address table, the packet bytes are
// copied into the payload store when the packet is stored, and the result
// is handed off. Clear returns nothing.
// After reset all TABLE_ENTRIES*PACKET_BYTES bytes of the payload store are
// zeroed, one byte per cycle, with ready low; configuration writes are
// taken during that pass.
// A result waits in the output register while the receiver stalls; the
// block takes further input until another result has to be handed off.
// ----------------------------------------------------------------------------
module beacon_advert_relay_filter_unit #(
    parameter int TABLE_ENTRIES = bar_flt_pkg::TABLE_ENTRIES_DEF,
    parameter int PACKET_BYTES  = bar_flt_pkg::PACKET_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bar_flt_in_if.sink                      i_in_ch,
    bar_flt_out_if.source                   o_out_ch,
    input  logic                            i_cfg_we,
    input  logic [bar_flt_pkg::CFG_IDX-1:0] i_cfg_index,
    input  logic [bar_flt_pkg::CFG_W-1:0]   i_cfg_data
);

    bar_flt_pkg::t_cmd    cmd;
    bar_flt_pkg::t_status st;
    logic                 in_ready;

    assign i_in_ch.ready = in_ready;

    bar_flt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_opcode   (i_in_ch.opcode),
        .i_last     (i_in_ch.last_byte),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    bar_flt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PACKET_BYTES  (PACKET_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_data_byte      (i_in_ch.data_byte),
        .i_first          (i_in_ch.first_byte),
        .i_last           (i_in_ch.last_byte),
        .i_addr           (i_in_ch.sender_address),
        .i_rd_slot        (i_in_ch.read_slot),
        .i_rd_index       (i_in_ch.read_index),
        .o_valid          (o_out_ch.valid),
        .i_ready          (o_out_ch.ready),
        .o_verdict        (o_out_ch.verdict),
        .o_stored_slot    (o_out_ch.stored_slot),
        .o_entry_total    (o_out_ch.entry_total),
        .o_vendor_packets (o_out_ch.vendor_packets),
        .o_read_data      (o_out_ch.read_data)
    );

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> (32'(o_out_ch.entry_total) <= TABLE_ENTRIES))
        else $error("entry total above table size");

    a_stored_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.verdict == bar_flt_pkg::V_STORED) |->
        ((10'(o_out_ch.stored_slot) + 10'd1) == o_out_ch.entry_total))
        else $error("stored slot not last entry");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.verdict != bar_flt_pkg::V_STORED) |->
        (o_out_ch.stored_slot == 9'd0))
        else $error("slot set without store");

    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ch.ready)
        else $error("ready during clearing pass");

endmodule
